// ===== hdl/box_blur_5x5_edge_clamp_core_assert.svh =====
// Assertion helpers for the checker file bbc_checker.sv.
`ifndef BOX_BLUR_5X5_EDGE_CLAMP_CORE_ASSERT_SVH
`define BOX_BLUR_5X5_EDGE_CLAMP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, quiet during reset.
`define BBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet during reset.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants and types of the 5x5 box blur core.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_SLOTS  = 8;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int CFGW_W  = 11;
    localparam int CFGH_W  = 13;
    localparam int SLOT_W  = 3;
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int DEPTH   = ROW_SLOTS * MAX_WIDTH;
    localparam int SUM_W   = 13;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 13;

    // divide by 25: multiply by 5243 then shift right by 17 (exact for sums <= 6375)
    localparam int RECIP_W  = 13;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int RECIP_SH = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic [CFGW_W-1:0] DEF_WIDTH  = 11'd640;
    localparam logic [CFGH_W-1:0] DEF_HEIGHT = 13'd480;

    // accumulator control from the sequencer
    typedef struct packed {
        logic clr;   // first read of a window
        logic take;  // a read was issued this cycle
        logic mul;   // scale the finished sum
    } acc_ctl_t;

endpackage

// ===== hdl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/bbc_sum.sv =====
// ----------------------------------------------------------------------------
// bbc_sum
// Window accumulator and divide-by-25 scaler.
// ----------------------------------------------------------------------------
module bbc_sum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bbc_pkg::acc_ctl_t          ctl,
    input  logic [bbc_pkg::PIX_W-1:0]  rdata,
    output logic [bbc_pkg::PIX_W-1:0]  quot
);

    logic                        take_reg;
    logic [bbc_pkg::SUM_W-1:0]   acc_reg;
    logic [bbc_pkg::SUM_W-1:0]   acc_next;
    logic [bbc_pkg::PROD_W-1:0]  prod_reg;

    // read data lands in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            take_reg <= 1'b0;
        end else begin
            take_reg <= ctl.take;
        end
    end

    // accumulate
    always_comb begin
        acc_next = acc_reg;
        if (ctl.clr) begin
            acc_next = '0;
        end else if (take_reg) begin
            acc_next = acc_reg + {{(bbc_pkg::SUM_W-bbc_pkg::PIX_W){1'b0}}, rdata};
        end
    end

    // full-width product of sum and reciprocal
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (ctl.mul) begin
            prod_reg <= {{bbc_pkg::RECIP_W{1'b0}}, acc_reg}
                      * {{bbc_pkg::SUM_W{1'b0}}, bbc_pkg::RECIP};
        end
    end

    assign quot = prod_reg[bbc_pkg::RECIP_SH +: bbc_pkg::PIX_W];

endmodule

// ===== hdl/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer: frame position, release window, line store addressing, output word.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbc_pkg::PIX_W-1:0]      s_pixel_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbc_pkg::PIX_W-1:0]      m_blurred_value,
    output logic [bbc_pkg::COL_W-1:0]      m_out_column,
    output logic [bbc_pkg::ROW_W-1:0]      m_out_row,
    output logic                           m_run_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbc_pkg::CFG_DAT_W-1:0]  cfg_data,
    output logic                           mem_we,
    output logic [bbc_pkg::ADDR_W-1:0]     mem_waddr,
    output logic [bbc_pkg::PIX_W-1:0]      mem_wdata,
    output logic                           mem_re,
    output logic [bbc_pkg::ADDR_W-1:0]     mem_raddr,
    output bbc_pkg::acc_ctl_t              acc_ctl,
    input  logic [bbc_pkg::PIX_W-1:0]      quot
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [2:0] TAP_LAST = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [bbc_pkg::CFGW_W-1:0] wcfg_reg, wcfg_next;
    logic [bbc_pkg::CFGH_W-1:0] hcfg_reg, hcfg_next;
    logic [bbc_pkg::COL_W-1:0]  col_reg, col_next;
    logic [bbc_pkg::ROW_W-1:0]  row_reg, row_next;

    logic [bbc_pkg::COL_W-1:0]  x_reg, x_next, xlo_reg, xlo_next, xhi_reg, xhi_next;
    logic [bbc_pkg::ROW_W-1:0]  y_reg, y_next, yhi_reg, yhi_next;
    logic [2:0]                 dx_reg, dx_next, dy_reg, dy_next;
    logic                       mval_reg, mval_next;
    logic [bbc_pkg::PIX_W-1:0]  mpix_reg;
    logic [bbc_pkg::COL_W-1:0]  mcol_reg;
    logic [bbc_pkg::ROW_W-1:0]  mrow_reg;
    logic                       mend_reg;

    logic [bbc_pkg::CFGW_W-1:0] w_eff;
    logic [bbc_pkg::CFGH_W-1:0] h_eff;
    logic [bbc_pkg::COL_W-1:0]  wm1;
    logic [bbc_pkg::ROW_W-1:0]  hm1;
    logic                       last_col, last_row, col_ok, row_ok;
    logic                       s_acc, cfg_acc, win_last;
    logic [bbc_pkg::COL_W:0]    tx, txm;
    logic [bbc_pkg::ROW_W:0]    ty, tym;
    logic [bbc_pkg::COL_W-1:0]  cx;
    logic [bbc_pkg::ROW_W-1:0]  cy;

    // effective frame size: zero acts as one, large values saturate
    always_comb begin
        if (wcfg_reg == '0) begin
            w_eff = bbc_pkg::CFGW_W'(1);
        end else if (wcfg_reg > bbc_pkg::CFGW_W'(bbc_pkg::MAX_WIDTH)) begin
            w_eff = bbc_pkg::CFGW_W'(bbc_pkg::MAX_WIDTH);
        end else begin
            w_eff = wcfg_reg;
        end
        if (hcfg_reg == '0) begin
            h_eff = bbc_pkg::CFGH_W'(1);
        end else if (hcfg_reg > bbc_pkg::CFGH_W'(bbc_pkg::MAX_HEIGHT)) begin
            h_eff = bbc_pkg::CFGH_W'(bbc_pkg::MAX_HEIGHT);
        end else begin
            h_eff = hcfg_reg;
        end
    end

    assign wm1 = bbc_pkg::COL_W'(w_eff - 1'b1);
    assign hm1 = bbc_pkg::ROW_W'(h_eff - 1'b1);

    assign last_col = (col_reg == wm1);
    assign last_row = (row_reg == hm1);
    assign col_ok   = last_col || (col_reg >= bbc_pkg::COL_W'(2));
    assign row_ok   = last_row || (row_reg >= bbc_pkg::ROW_W'(2));

    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign win_last  = (x_reg == xhi_reg) && (y_reg == yhi_reg);

    // line store write of the incoming pixel
    assign mem_we    = s_acc;
    assign mem_waddr = {row_reg[bbc_pkg::SLOT_W-1:0], col_reg};
    assign mem_wdata = s_pixel_value;

    // neighbour address with clamping to the frame
    always_comb begin
        tx  = {1'b0, x_reg} + {{(bbc_pkg::COL_W-2){1'b0}}, dx_reg};
        ty  = {1'b0, y_reg} + {{(bbc_pkg::ROW_W-2){1'b0}}, dy_reg};
        txm = tx - 2'd2;
        tym = ty - 2'd2;
        if (tx < 2'd2) begin
            cx = '0;
        end else if (txm > {1'b0, wm1}) begin
            cx = wm1;
        end else begin
            cx = txm[bbc_pkg::COL_W-1:0];
        end
        if (ty < 2'd2) begin
            cy = '0;
        end else if (tym > {1'b0, hm1}) begin
            cy = hm1;
        end else begin
            cy = tym[bbc_pkg::ROW_W-1:0];
        end
    end

    assign mem_re    = (state_reg == ST_RD);
    assign mem_raddr = {cy[bbc_pkg::SLOT_W-1:0], cx};

    assign acc_ctl.clr  = (state_reg == ST_RD) && (dx_reg == '0) && (dy_reg == '0);
    assign acc_ctl.take = (state_reg == ST_RD);
    assign acc_ctl.mul  = (state_reg == ST_MUL);

    // sequencer
    always_comb begin
        state_next = state_reg;
        wcfg_next  = wcfg_reg;
        hcfg_next  = hcfg_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        yhi_next   = yhi_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        mval_next  = mval_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_acc) begin
                    if (cfg_index == bbc_pkg::REG_IMAGE_WIDTH) begin
                        wcfg_next = cfg_data[bbc_pkg::CFGW_W-1:0];
                        col_next  = '0;
                        row_next  = '0;
                    end else if (cfg_index == bbc_pkg::REG_IMAGE_HEIGHT) begin
                        hcfg_next = cfg_data;
                        col_next  = '0;
                        row_next  = '0;
                    end
                end else if (s_acc) begin
                    // release window of this pixel
                    xlo_next = (col_reg >= bbc_pkg::COL_W'(2)) ? col_reg - 2'd2 : '0;
                    xhi_next = last_col ? wm1 : col_reg - 2'd2;
                    yhi_next = last_row ? hm1 : row_reg - 2'd2;
                    x_next   = (col_reg >= bbc_pkg::COL_W'(2)) ? col_reg - 2'd2 : '0;
                    y_next   = (row_reg >= bbc_pkg::ROW_W'(2)) ? row_reg - 2'd2 : '0;
                    dx_next  = '0;
                    dy_next  = '0;
                    if (col_ok && row_ok) begin
                        state_next = ST_RD;
                    end
                    // advance raster position
                    if (last_col) begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            ST_RD: begin
                if (dx_reg == TAP_LAST) begin
                    dx_next = '0;
                    if (dy_reg == TAP_LAST) begin
                        dy_next    = '0;
                        state_next = ST_FIN;
                    end else begin
                        dy_next = dy_reg + 1'b1;
                    end
                end else begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            ST_FIN: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                mval_next  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    mval_next = 1'b0;
                    if (win_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                        if (x_reg == xhi_reg) begin
                            x_next = xlo_reg;
                            y_next = y_reg + 1'b1;
                        end else begin
                            x_next = x_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wcfg_reg  <= bbc_pkg::DEF_WIDTH;
            hcfg_reg  <= bbc_pkg::DEF_HEIGHT;
            col_reg   <= '0;
            row_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wcfg_reg  <= wcfg_next;
            hcfg_reg  <= hcfg_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            mval_reg  <= mval_next;
        end
    end

    // window coordinates and output word
    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        xlo_reg <= xlo_next;
        xhi_reg <= xhi_next;
        yhi_reg <= yhi_next;
        if (state_reg == ST_LOAD) begin
            mpix_reg <= quot;
            mcol_reg <= x_reg;
            mrow_reg <= y_reg;
            mend_reg <= win_last;
        end
    end

    assign m_valid         = mval_reg;
    assign m_blurred_value = mpix_reg;
    assign m_out_column    = mcol_reg;
    assign m_out_row       = mrow_reg;
    assign m_run_end       = mend_reg;

endmodule

// ===== hdl/box_blur_5x5_edge_clamp_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_5x5_edge_clamp_core
// 5x5 box blur with replicated borders over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one 8-bit pixel word per handshake in raster order.
//   m_* gives blurred words with column, row and a run-end flag on the last
//   word released by an input pixel (0 to 9 words per pixel).
//   cfg_* writes image_width (index 0) or image_height (index 1); a write
//   restarts the frame at column 0, row 0. Only accepted while idle.
// Sequence:
//   A pixel with no release only writes the line store. Each released word
//   costs 25 reads of the single read port of the line store, then a state
//   to catch the last read, a multiply state and a load state before m_valid
//   rises; the words of a pixel are made one after another, and the next
//   pixel is taken only after the last word's handshake.
// Reset:
//   Position returns to 0,0 and the size registers to 640 x 480. The line
//   store is not cleared; only entries already written are read.
// Stall:
//   While m_ready is low the word holds on m_*, and no pixel is taken.
// ----------------------------------------------------------------------------
module box_blur_5x5_edge_clamp_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbc_pkg::PIX_W-1:0]      s_pixel_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbc_pkg::PIX_W-1:0]      m_blurred_value,
    output logic [bbc_pkg::COL_W-1:0]      m_out_column,
    output logic [bbc_pkg::ROW_W-1:0]      m_out_row,
    output logic                           m_run_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbc_pkg::CFG_DAT_W-1:0]  cfg_data
);

    logic                         mem_we, mem_re;
    logic [bbc_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [bbc_pkg::PIX_W-1:0]    mem_wdata, mem_rdata, quot;
    bbc_pkg::acc_ctl_t            acc_ctl;

    // sequencer
    bbc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_value   (s_pixel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blurred_value (m_blurred_value),
        .m_out_column    (m_out_column),
        .m_out_row       (m_out_row),
        .m_run_end       (m_run_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .acc_ctl         (acc_ctl),
        .quot            (quot)
    );

    // eight-row line store
    bbc_ram #(
        .WIDTH (bbc_pkg::PIX_W),
        .DEPTH (bbc_pkg::DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // window sum and scaling
    bbc_sum u_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .rdata   (mem_rdata),
        .quot    (quot)
    );

endmodule

// ===== hdl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_5x5_edge_clamp_core_assert.svh"

module bbc_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_ready,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_run_end,
    input  logic                           cfg_ready
);

    // a pending word holds until taken
    `BBC_ASSERT_NEXT(a_mvalid_hold, m_valid && !m_ready, m_valid, "m_valid dropped")

    // no pixel taken while a word waits
    `BBC_ASSERT_NOW(a_no_in_while_out, m_valid, !s_ready, "s_ready with word pending")

    // no register write while a word waits
    `BBC_ASSERT_NOW(a_no_cfg_while_out, m_valid, !cfg_ready, "cfg_ready with word pending")

    // more words of the same pixel follow, so input stays closed
    `BBC_ASSERT_NEXT(a_run_continues, m_valid && m_ready && !m_run_end, !s_ready, "run open")

endmodule

bind box_blur_5x5_edge_clamp_core bbc_checker u_bbc_checker (.*);
